// ===== rtl/core/sitda_pkg.sv =====
// Package with shared constants and types for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int ROOM_BITS      = 4;
    localparam int CHAR_BITS      = 8;
    localparam int COUNT_BITS     = 4;

    localparam logic [ROOM_BITS-1:0] MAX_ROOM   = 4'd11;
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_BITS-1:0] MINUS_SIGN = 8'h2D;

    // Double dabble: a BCD digit of five or more gets three added before the shift.
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT,
        ST_REFUSE
    } t_state;

endpackage

// ===== rtl/core/sitda_if.sv =====
// Handshake interfaces for the input and result channels of the decimal text block.
`timescale 1ns / 1ps

interface sitda_in_if
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_BITS-1:0] value;
    logic [ROOM_BITS-1:0]        room;

    modport source (output valid, output value, output room, input ready);
    modport sink   (input valid, input value, input room, output ready);
endinterface

interface sitda_out_if
    import sitda_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CHAR_BITS-1:0]  character;
    logic                  last;
    logic                  refused;
    logic [COUNT_BITS-1:0] count;

    modport source (output valid, output character, output last, output refused,
                    output count, input ready);
    modport sink   (input valid, input character, input last, input refused,
                    input count, output ready);
endinterface

// ===== rtl/core/signed_int_to_decimal_ascii_top.sv =====
// Signed integer to decimal ASCII text converter, top level.
`timescale 1ns / 1ps

// Takes one signed VALUE_BITS-bit word with a room limit and returns its decimal
// text one character word at a time: a leading '-' for negatives, then digits
// from the most significant down, the final word marked with last and the
// character count. Text longer than the room (clamped to 11) gives a single
// word flagged refused with count 0. The block handles one word at a time and
// is not ready while it works. A word is taken, run through VALUE_BITS shifts
// of the double-dabble shift/add-3 unit, then the leading digit is found by
// stripping leading zero digits (up to ND-1, where ND = VALUE_BITS*301/1000+1,
// 10 at 32 bits), then one character is emitted per word the output side takes.
// Stripping and emitting trade off against each other.
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sitda_in_if.sink      i_in,
    sitda_out_if.source   o_out
);

    localparam int ND    = (VALUE_BITS * 301) / 1000 + 1;
    localparam int W_BIT = $clog2(VALUE_BITS);
    localparam int W_ND  = $clog2(ND + 1);
    localparam int W_N   = $clog2(ND + 2);
    localparam int W_CMP = (W_N > ROOM_BITS) ? W_N : ROOM_BITS;
    localparam logic [W_BIT-1:0] LAST_BIT = W_BIT'(VALUE_BITS - 1);

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_mag;
    logic [4*ND-1:0]       r_bcd;
    logic [4*ND-1:0]       n_bcd_adj;
    logic [W_BIT-1:0]      r_bit_cnt;
    logic [W_ND-1:0]       r_nd;
    logic [W_N-1:0]        r_left;
    logic [W_N-1:0]        r_total;
    logic [W_N-1:0]        n_total;
    logic [ROOM_BITS-1:0]  r_room;
    logic                  r_neg;
    logic                  r_sign_pending;

    logic [3:0]            top_digit;
    logic                  scan_done;
    logic                  fits;
    logic                  out_take;
    logic                  in_take;

    assign top_digit = r_bcd[4*ND-1 -: 4];
    assign scan_done = (top_digit != 4'd0) || (r_nd == W_ND'(1));
    assign n_total   = W_N'(r_nd) + W_N'(r_neg);
    assign fits      = (W_CMP'(n_total) <= W_CMP'(r_room));
    assign out_take  = o_out.valid && o_out.ready;
    assign in_take   = i_in.valid && i_in.ready;

    // Add-3 correction on every digit in parallel ahead of the shift.
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (r_bcd[4*d +: 4] >= DABBLE_LIMIT) begin
                n_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + DABBLE_ADD;
            end else begin
                n_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_take) n_state = ST_CONV;
            ST_CONV:   if (r_bit_cnt == LAST_BIT) n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = fits ? ST_EMIT : ST_REFUSE;
                end
            end
            ST_EMIT:   if (out_take && (r_left == W_N'(1))) n_state = ST_IDLE;
            ST_REFUSE: if (out_take) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        o_out.valid     = (r_state == ST_EMIT) || (r_state == ST_REFUSE);
        o_out.refused   = (r_state == ST_REFUSE);
        o_out.last      = (r_state == ST_REFUSE) || (r_left == W_N'(1));
        o_out.character = '0;
        o_out.count     = '0;
        if (r_state == ST_EMIT) begin
            o_out.character = r_sign_pending ? MINUS_SIGN : (ASCII_ZERO | {4'd0, top_digit});
            if (r_left == W_N'(1)) begin
                o_out.count = COUNT_BITS'(r_total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_neg     <= i_in.value[VALUE_BITS-1];
                    r_mag     <= i_in.value[VALUE_BITS-1] ? (~i_in.value + 1'b1) : i_in.value;
                    r_room    <= (i_in.room > MAX_ROOM) ? MAX_ROOM : i_in.room;
                    r_bcd     <= '0;
                    r_bit_cnt <= '0;
                end
            end
            ST_CONV: begin
                r_bcd     <= {n_bcd_adj[4*ND-2:0], r_mag[VALUE_BITS-1]};
                r_mag     <= {r_mag[VALUE_BITS-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + 1'b1;
                r_nd      <= W_ND'(ND);
            end
            ST_SCAN: begin
                if (scan_done) begin
                    r_left         <= n_total;
                    r_total        <= n_total;
                    r_sign_pending <= r_neg;
                end else begin
                    r_bcd <= {r_bcd[4*ND-5:0], 4'd0};
                    r_nd  <= r_nd - 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_take) begin
                    r_left <= r_left - 1'b1;
                    if (r_sign_pending) begin
                        r_sign_pending <= 1'b0;
                    end else begin
                        r_bcd <= {r_bcd[4*ND-5:0], 4'd0};
                    end
                end
            end
            ST_REFUSE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/sitda_checker.sv =====
// Port-level assertions for the decimal text block and their bind to the top level.
`timescale 1ns / 1ps

module sitda_checker
    import sitda_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CHAR_BITS-1:0]  i_character,
    input logic                  i_last,
    input logic                  i_refused,
    input logic [COUNT_BITS-1:0] i_count
);

    // A refused word is a lone final word with no text.
    a_refused_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_refused) |-> (i_last && (i_count == '0) && (i_character == '0)))
        else $error("refused word is malformed");

    // Only the final word carries a count, and a written run holds at most eleven.
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_refused) |->
            (i_last ? ((i_count != '0) && (i_count <= COUNT_BITS'(MAX_ROOM)))
                    : (i_count == '0)))
        else $error("count on wrong word or out of range");

    // Written words are the minus sign or a digit.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_refused) |->
            ((i_character == MINUS_SIGN) ||
             ((i_character >= ASCII_ZERO) && (i_character <= ASCII_ZERO + 8'd9))))
        else $error("character outside the decimal text set");

    // No new input while a run is in progress.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while results pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_character) &&
                                           $stable(i_last) && $stable(i_count)))
        else $error("stalled result word changed");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_character (o_out.character),
    .i_last      (o_out.last),
    .i_refused   (o_out.refused),
    .i_count     (o_out.count)
);
